>>> hw/rtl/wav_dac_pkg.sv
// Shared types and constants for the WAV stream to DAC sample converter.
// No dependencies; imported by wav_stream_to_dac_samples.

package wav_dac_pkg;

	// Width of each DAC code (8 to 16).
	localparam int unsigned DAC_WIDTH = 12;

	// Header tags as they sit in the shift register after four bytes (little endian).
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// Header byte positions at which a tag or field is complete.
	localparam logic [5:0] POS_RIFF_END = 6'd3;
	localparam logic [5:0] POS_WAVE_END = 6'd11;
	localparam logic [5:0] POS_FMT_END  = 6'd15;
	localparam logic [5:0] POS_CHAN_END = 6'd23;
	localparam logic [5:0] POS_RATE_END = 6'd27;
	localparam logic [5:0] POS_BITS_END = 6'd35;
	localparam logic [5:0] POS_DATA_END = 6'd39;
	localparam logic [5:0] POS_SIZE_END = 6'd43;

	// Offset added to a signed 16-bit sample to make it unsigned.
	localparam logic [15:0] MID_SCALE = 16'h8000;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_DATA   = 4'b0010,
		PH_ERROR  = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		KIND_SAMPLE  = 3'd0,
		KIND_HEADER  = 3'd1,
		KIND_BAD_TAG = 3'd2,
		KIND_BAD_FMT = 3'd3,
		KIND_END     = 3'd4
	} kind_t;

endpackage

>>> hw/rtl/wav_stream_to_dac_samples.sv
// WAV stream to DAC sample converter: header parser, frame assembler and output register.
// Depends on wav_dac_pkg for the phase and result kind types and the header constants.
//
// Usage
// The input channel (in_valid, in_ready, file_byte, start_of_file) carries one byte of a
// WAV file per word. The first 44 bytes are the canonical little-endian header; a word with
// start_of_file high restarts parsing and is itself taken as header byte zero, in any phase.
// The output channel (out_valid, out_ready, kind and the data fields) carries at most one
// result word per input word: a header acceptance with rate, channel count and sample bits,
// a bad tag or unsupported format error (both sticky until restart), one pair of DAC codes
// per complete PCM frame, or an end of data marker for the first byte after the data size.
// A result is held in the output register in the cycle after its byte is accepted. Unless
// the receiver stalls, throughput is one byte per cycle, set by the single state update that
// every byte makes (header shift, byte counter and frame position); bytes that give no result
// need no output slot. When the receiver stalls, the result stays in the output register and
// in_ready drops until it is taken; in the cycle it is taken, a new byte is accepted again.
// Reset puts the parser at header byte zero with no result pending; an error or end of data
// leaves the block silent until a word with start_of_file arrives.

module wav_stream_to_dac_samples (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          file_byte,
	input  logic                                start_of_file,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          kind,
	output logic [wav_dac_pkg::DAC_WIDTH-1:0]   dac_left,
	output logic [wav_dac_pkg::DAC_WIDTH-1:0]   dac_right,
	output logic [31:0]                         rate_hz,
	output logic [15:0]                         channel_count,
	output logic [15:0]                         sample_bits
);
	import wav_dac_pkg::*;

	// Parser state.
	phase_t      phase_q;
	logic [5:0]  hdr_pos_q;
	logic [31:0] shift_q;
	logic [15:0] chan_q;
	logic [15:0] bits_q;
	logic [31:0] rate_q;
	logic [31:0] bytes_left_q;
	logic [1:0]  frame_pos_q;

	// Output register.
	logic                 out_valid_q;
	kind_t                kind_q;
	logic [DAC_WIDTH-1:0] left_q;
	logic [DAC_WIDTH-1:0] right_q;
	logic [31:0]          rate_out_q;
	logic [15:0]          chan_out_q;
	logic [15:0]          bits_out_q;

	// Next state and result of the byte on the input.
	phase_t               phase_d;
	logic [5:0]           hdr_pos_d;
	logic [31:0]          shift_d;
	logic [15:0]          chan_d;
	logic [15:0]          bits_d;
	logic [31:0]          rate_d;
	logic [31:0]          bytes_left_d;
	logic [1:0]           frame_pos_d;
	logic                 res_valid;
	kind_t                res_kind;
	logic [DAC_WIDTH-1:0] res_left;
	logic [DAC_WIDTH-1:0] res_right;
	logic [31:0]          res_rate;
	logic [15:0]          res_chan;
	logic [15:0]          res_bits;

	// A restart clears the parser before the byte is looked at.
	phase_t      eff_phase;
	logic [5:0]  eff_pos;
	logic [31:0] eff_shift;
	logic [31:0] hdr_shift;
	logic [31:0] frame_word;
	logic        stereo;
	logic        wide;
	logic [1:0]  frame_last;
	logic        tag_bad;
	logic        fmt_ok;
	logic        in_fire;

	// Turns one PCM sample into an unsigned DAC code.
	function automatic logic [DAC_WIDTH-1:0] to_code(input logic [15:0] smp, input logic is16);
		logic [15:0] biased;
		logic [DAC_WIDTH-1:0] code;
		biased = smp + MID_SCALE;
		if (is16) begin
			code = biased[15 -: DAC_WIDTH];
		end else begin
			code = DAC_WIDTH'(smp[7:0]) << (DAC_WIDTH - 8);
		end
		return code;
	endfunction

	assign in_fire  = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	assign eff_phase = start_of_file ? PH_HEADER : phase_q;
	assign eff_pos   = start_of_file ? 6'd0 : hdr_pos_q;
	assign eff_shift = start_of_file ? 32'd0 : shift_q;
	assign hdr_shift = {file_byte, eff_shift[31:8]};

	// Frames are one, two or four bytes long; frame_last is the index of the final byte.
	assign stereo     = (chan_q == 16'd2);
	assign wide       = (bits_q == 16'd16);
	assign frame_last = {stereo && wide, stereo || wide};
	assign frame_word = shift_q | ({24'd0, file_byte} << {frame_pos_q, 3'b000});

	assign tag_bad = ((eff_pos == POS_RIFF_END) && (hdr_shift != TAG_RIFF))
		|| ((eff_pos == POS_WAVE_END) && (hdr_shift != TAG_WAVE))
		|| ((eff_pos == POS_FMT_END) && (hdr_shift != TAG_FMT))
		|| ((eff_pos == POS_DATA_END) && (hdr_shift != TAG_DATA));

	assign fmt_ok = ((chan_q == 16'd1) || (chan_q == 16'd2))
		&& ((bits_q == 16'd8) || (bits_q == 16'd16));

	always_comb begin
		phase_d      = eff_phase;
		hdr_pos_d    = eff_pos;
		shift_d      = eff_shift;
		chan_d       = chan_q;
		bits_d       = bits_q;
		rate_d       = rate_q;
		bytes_left_d = bytes_left_q;
		frame_pos_d  = frame_pos_q;
		res_valid    = 1'b0;
		res_kind     = KIND_SAMPLE;
		res_left     = '0;
		res_right    = '0;
		res_rate     = '0;
		res_chan     = '0;
		res_bits     = '0;

		unique case (eff_phase)
			PH_HEADER: begin
				shift_d   = hdr_shift;
				hdr_pos_d = eff_pos + 6'd1;
				if (tag_bad) begin
					phase_d   = PH_ERROR;
					res_valid = 1'b1;
					res_kind  = KIND_BAD_TAG;
				end else begin
					unique case (eff_pos)
						POS_CHAN_END: chan_d = hdr_shift[31:16];
						POS_RATE_END: rate_d = hdr_shift;
						POS_BITS_END: bits_d = hdr_shift[31:16];
						POS_SIZE_END: begin
							bytes_left_d = hdr_shift;
							shift_d      = '0;
							frame_pos_d  = 2'd0;
							res_valid    = 1'b1;
							if (fmt_ok) begin
								phase_d  = PH_DATA;
								res_kind = KIND_HEADER;
								res_rate = rate_q;
								res_chan = chan_q;
								res_bits = bits_q;
							end else begin
								phase_d  = PH_ERROR;
								res_kind = KIND_BAD_FMT;
							end
						end
						default: ;
					endcase
				end
			end
			PH_DATA: begin
				if (bytes_left_q == 32'd0) begin
					phase_d   = PH_DONE;
					res_valid = 1'b1;
					res_kind  = KIND_END;
				end else begin
					bytes_left_d = bytes_left_q - 32'd1;
					if (frame_pos_q == frame_last) begin
						shift_d     = '0;
						frame_pos_d = 2'd0;
						res_valid   = 1'b1;
						res_kind    = KIND_SAMPLE;
						if (wide) begin
							res_left  = to_code(frame_word[15:0], 1'b1);
							res_right = to_code(stereo ? frame_word[31:16]
								: frame_word[15:0], 1'b1);
						end else begin
							res_left  = to_code({8'd0, frame_word[7:0]}, 1'b0);
							res_right = to_code({8'd0, stereo ? frame_word[15:8]
								: frame_word[7:0]}, 1'b0);
						end
					end else begin
						shift_d     = frame_word;
						frame_pos_d = frame_pos_q + 2'd1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_pos_q    <= '0;
			shift_q      <= '0;
			bytes_left_q <= '0;
			frame_pos_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				phase_q      <= phase_d;
				hdr_pos_q    <= hdr_pos_d;
				shift_q      <= shift_d;
				bytes_left_q <= bytes_left_d;
				frame_pos_q  <= frame_pos_d;
				out_valid_q  <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Header fields and the result payload carry no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			chan_q <= chan_d;
			bits_q <= bits_d;
			rate_q <= rate_d;
		end
		if (in_fire && res_valid) begin
			kind_q     <= res_kind;
			left_q     <= res_left;
			right_q    <= res_right;
			rate_out_q <= res_rate;
			chan_out_q <= res_chan;
			bits_out_q <= res_bits;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign dac_left      = left_q;
	assign dac_right     = right_q;
	assign rate_hz       = rate_out_q;
	assign channel_count = chan_out_q;
	assign sample_bits   = bits_out_q;

	// Once stopped by an error or the end of data, a byte without restart gives nothing.
	a_silent_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !start_of_file && ((phase_q == PH_ERROR) || (phase_q == PH_DONE)))
		|=> !out_valid)
		else $error("result produced after error or end of data");

	// A header acceptance is only ever pending while the parser is in the data phase.
	a_header_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_HEADER)) |-> (phase_q == PH_DATA))
		else $error("header accepted but parser not in data phase");

	// The data phase is entered only with a supported format.
	a_data_format: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> fmt_ok)
		else $error("data phase with unsupported format");

	// The frame position never passes the last byte of a frame.
	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (frame_pos_q <= frame_last))
		else $error("frame position beyond frame length");

endmodule
